[rtl/core/signed_int_to_decimal_ascii_macros.svh]
// Assertion macros for the decimal printer checker.
`ifndef SIGNED_INT_TO_DECIMAL_ASCII_MACROS_SVH
`define SIGNED_INT_TO_DECIMAL_ASCII_MACROS_SVH

// Checked only outside reset.
`define SIDA_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Checked in reset too.
`define SIDA_ASSERT_RST(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

[rtl/core/sida_pkg.sv]
package sida_pkg;

  localparam int NUM_BITS   = 32;
  localparam int NUM_DIGITS = 10;
  localparam int BCD_W      = 4 * NUM_DIGITS;
  localparam int CNT_W      = $clog2(NUM_BITS + 1);
  localparam int REM_W      = $clog2(NUM_DIGITS + 1);

  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_MINUS = 8'h2D;

  typedef logic [BCD_W-1:0]    bcd_t;
  typedef logic [3:0]          digit_t;
  typedef logic [NUM_BITS-1:0] mag_t;

  typedef struct packed {
    logic load;
    logic neg;
  } emit_ctl_t;

endpackage

[rtl/core/sida_dabble.sv]
module sida_dabble (
  input  logic          clk,
  input  logic          rst,
  input  logic          load,
  input  sida_pkg::mag_t value,
  output sida_pkg::bcd_t bcd,
  output logic          done
);
  import sida_pkg::*;

  mag_t             shreg;
  bcd_t             bcd_adj;
  logic [CNT_W-1:0] cnt;
  logic             active;

  // add 3 to every digit of 5 or more before the shift
  always_comb begin
    for (int i = 0; i < NUM_DIGITS; i++) begin
      if (bcd[4*i +: 4] >= 4'd5) begin
        bcd_adj[4*i +: 4] = bcd[4*i +: 4] + 4'd3;
      end else begin
        bcd_adj[4*i +: 4] = bcd[4*i +: 4];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      active <= 1'b0;
      done   <= 1'b0;
      cnt    <= '0;
    end else begin
      done <= 1'b0;
      if (load) begin
        active <= 1'b1;
        cnt    <= CNT_W'(NUM_BITS);
      end else if (active) begin
        cnt <= cnt - 1'b1;
        if (cnt == CNT_W'(1)) begin
          active <= 1'b0;
          done   <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      shreg <= value;
      bcd   <= '0;
    end else if (active) begin
      {bcd, shreg} <= {bcd_adj[BCD_W-2:0], shreg, 1'b0};
    end
  end

endmodule

[rtl/core/sida_emit.sv]
module sida_emit (
  input  logic                clk,
  input  logic                rst,
  input  sida_pkg::emit_ctl_t ctl,
  input  sida_pkg::bcd_t      bcd,
  output logic [7:0]          character,
  output logic                last_char,
  output logic                strobe
);
  import sida_pkg::*;

  bcd_t             digs;
  logic [REM_W-1:0] remaining;
  logic             active;
  logic             minus_pending;
  logic             started;
  digit_t           d;
  logic             show;

  assign d    = digs[BCD_W-1 -: 4];
  assign show = started || (d != 4'd0) || (remaining == REM_W'(1));

  always_ff @(posedge clk) begin
    if (rst) begin
      active        <= 1'b0;
      minus_pending <= 1'b0;
      started       <= 1'b0;
      strobe        <= 1'b0;
      remaining     <= '0;
    end else begin
      strobe <= 1'b0;
      if (ctl.load) begin
        active        <= 1'b1;
        minus_pending <= ctl.neg;
        started       <= 1'b0;
        remaining     <= REM_W'(NUM_DIGITS);
      end else if (active) begin
        if (minus_pending) begin
          minus_pending <= 1'b0;
          strobe        <= 1'b1;
        end else begin
          remaining <= remaining - 1'b1;
          if (show) begin
            started <= 1'b1;
            strobe  <= 1'b1;
          end
          if (remaining == REM_W'(1)) begin
            active <= 1'b0;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      digs <= bcd;
    end else if (active && !minus_pending) begin
      digs <= {digs[BCD_W-5:0], 4'd0};
    end
    if (active) begin
      if (minus_pending) begin
        character <= CH_MINUS;
        last_char <= 1'b0;
      end else begin
        character <= CH_ZERO + {4'd0, d};
        last_char <= (remaining == REM_W'(1));
      end
    end
  end

endmodule

[rtl/core/signed_int_to_decimal_ascii.sv]
// Channel   Direction  Handshake               Payload
// command   in         start, busy             number
// result    out        strobe (one cycle)      character, last_char
//
// An item passes through 32 one-bit shift-and-adjust steps in the
// binary-to-BCD register, a handoff to the emitter, then an optional minus
// sign and the ten decimal digit positions in turn, and one output register.
// Reset (rst, synchronous) returns to idle and drops busy and strobe.
// busy stays high from acceptance until the last character's cycle ends.
// The receiver cannot stall; each character is shown for one cycle.
module signed_int_to_decimal_ascii (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic signed [31:0] number,
  output logic [7:0]         character,
  output logic               last_char,
  output logic               strobe
);
  import sida_pkg::*;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_CONV = 2'd1;
  localparam logic [1:0] ST_EMIT = 2'd2;

  logic [1:0] state;
  logic [1:0] state_next;
  logic       neg;
  logic       accept;
  logic       conv_done;
  mag_t       raw;
  mag_t       magnitude;
  bcd_t       bcd;
  emit_ctl_t  ectl;

  assign accept    = start && !busy;
  assign busy      = (state != ST_IDLE);
  assign raw       = mag_t'(number);
  assign magnitude = raw[NUM_BITS-1] ? (~raw + 1'b1) : raw;

  assign ectl.load = conv_done;
  assign ectl.neg  = neg;

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (start) state_next = ST_CONV;
      end
      ST_CONV: begin
        if (conv_done) state_next = ST_EMIT;
      end
      ST_EMIT: begin
        if (strobe && last_char) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      neg <= raw[NUM_BITS-1];
    end
  end

  sida_dabble u_dabble (
    .clk   (clk),
    .rst   (rst),
    .load  (accept),
    .value (magnitude),
    .bcd   (bcd),
    .done  (conv_done)
  );

  sida_emit u_emit (
    .clk       (clk),
    .rst       (rst),
    .ctl       (ectl),
    .bcd       (bcd),
    .character (character),
    .last_char (last_char),
    .strobe    (strobe)
  );

endmodule

[rtl/core/sida_check.sv]
`include "signed_int_to_decimal_ascii_macros.svh"

module sida_check (
  input logic       clk,
  input logic       rst,
  input logic       start,
  input logic       busy,
  input logic [7:0] character,
  input logic       last_char,
  input logic       strobe
);
  import sida_pkg::*;

  `SIDA_ASSERT(a_strobe_busy, strobe |-> busy, "character outside a busy run")
  `SIDA_ASSERT(a_start_busy, start && !busy |=> busy, "accepted command did not raise busy")
  `SIDA_ASSERT(a_last_idle, strobe && last_char |=> !busy, "busy held after last character")
  `SIDA_ASSERT(a_minus_not_last, strobe && character == CH_MINUS |-> !last_char, "run ended on minus")
  `SIDA_ASSERT_RST(a_reset, rst |=> !busy && !strobe, "reset left block active")

endmodule

bind signed_int_to_decimal_ascii sida_check u_check (.*);

[verif/signed_int_to_decimal_ascii_tb.sv]
module signed_int_to_decimal_ascii_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import sida_pkg::*;

  localparam int NUM_RANDOM   = 337;
  localparam int IDLE_LIMIT   = 1000;
  localparam int DRAIN_CYCLES = 60;

  typedef struct {
    logic [7:0] ch;
    logic       last;
  } text_char_t;

  class decimal_text_scoreboard;
    text_char_t expected_chars[$];
    int         errors;

    function new();
      errors = 0;
    endfunction

    function void push_char(logic [7:0] ch, logic last);
      text_char_t c;
      c.ch   = ch;
      c.last = last;
      expected_chars.push_back(c);
    endfunction

    // Expected text of one transferred number.
    function void note_number(logic signed [31:0] n);
      logic [31:0] mag;
      logic [3:0]  digs[NUM_DIGITS];
      int          nd;
      nd  = 0;
      mag = n[31] ? (32'd0 - n) : n;
      if (mag == 32'd0) begin
        push_char(CH_ZERO, 1'b1);
        return;
      end
      while (mag != 32'd0) begin
        digs[nd] = 4'(mag % 10);
        mag      = mag / 10;
        nd++;
      end
      if (n[31]) push_char(CH_MINUS, 1'b0);
      for (int j = nd - 1; j >= 0; j--) push_char(CH_ZERO + digs[j], j == 0);
    endfunction

    function void check_char(logic [7:0] ch, logic last);
      text_char_t want;
      if (expected_chars.size() == 0) begin
        $error("character %h last_char %b with nothing expected", ch, last);
        errors++;
        return;
      end
      want = expected_chars.pop_front();
      if (ch !== want.ch) begin
        $error("character: expected %h, got %h", want.ch, ch);
        errors++;
      end
      if (last !== want.last) begin
        $error("last_char: expected %b, got %b", want.last, last);
        errors++;
      end
    endfunction
  endclass

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               start = 1'b0;
  logic signed [31:0] number = '0;
  logic               busy;
  logic [7:0]         character;
  logic               last_char;
  logic               strobe;
  int                 idle_cycles = 0;

  decimal_text_scoreboard sb = new();

  signed_int_to_decimal_ascii DUT (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .busy      (busy),
    .number    (number),
    .character (character),
    .last_char (last_char),
    .strobe    (strobe)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    if (!rst && strobe) sb.check_char(character, last_char);
  end

  always @(posedge clk) begin
    if (rst || (start && !busy) || strobe) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // One command transfer, after a random gap.
  task automatic send_number(logic signed [31:0] val);
    int gap = $urandom_range(0, 4);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start  <= 1'b1;
    number <= val;
    do @(posedge clk); while (busy);
    sb.note_number(val);
  endtask

  // Mostly numbers of a random digit count, some full-range words.
  function automatic logic signed [31:0] pick_number();
    int unsigned        ndig;
    longint unsigned    lo;
    longint unsigned    hi;
    logic signed [31:0] v;
    if ($urandom_range(0, 3) == 0) begin
      v = $urandom;
    end else begin
      ndig = $urandom_range(1, NUM_DIGITS);
      lo   = 1;
      repeat (ndig - 1) lo = lo * 10;
      hi = lo * 10 - 1;
      if (hi > 64'h7FFF_FFFF) hi = 64'h7FFF_FFFF;
      v = $urandom_range(int'(hi), int'(lo));
      if ($urandom_range(0, 1) == 1) v = -v;
    end
    return v;
  endfunction

  initial begin
    logic signed [31:0] directed[$];
    directed = '{0, 1, -1, 9, -9, 10, -10, 99, 100, -100, 12345, -54321,
                 999999999, -999999999, 1000000000, -1000000000,
                 1234567890, -1234567890, 2147483647, -2147483647,
                 32'h8000_0000, 32'h5555_5555, 32'hAAAA_AAAA};
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    foreach (directed[i]) send_number(directed[i]);
    repeat (NUM_RANDOM) send_number(pick_number());
    start <= 1'b0;
    while (sb.expected_chars.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.errors == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
